@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when the trigger holds, the consequence holds in the same cycle.
`define SRLE_ASSERT_IMPL(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/srle_pkg.sv @@
// ----------------------------------------------------------------------------
// Subpicture RLE decoder package
// Types, constants and register indexes shared by the decoder modules.
// ----------------------------------------------------------------------------
package srle_pkg;

  // Field widths.
  localparam int unsigned SideW  = 13;
  localparam int unsigned PosW   = 12;
  localparam int unsigned ColorW = 2;
  localparam int unsigned PartW  = 6;

  // Defaults.
  localparam int unsigned MAX_SIDE_DEF   = 4096;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  localparam logic [SideW-1:0] LineWidthRst     = 13'd720;
  localparam logic [SideW-1:0] PictureHeightRst = 13'd576;
  localparam logic             FirstRowRst      = 1'b0;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH     = 2'd0,
    CFG_PICTURE_HEIGHT = 2'd1,
    CFG_FIRST_ROW      = 2'd2
  } cfg_idx_e;

  // Decoder state carried from nibble to nibble.
  typedef struct packed {
    logic [SideW-1:0] column_pos;
    logic [SideW-1:0] row_pos;
    logic [PartW-1:0] partial_code;
    logic [1:0]       nibbles_held;
    logic             field_finished;
  } dec_state_t;

  // One decoded run.
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [SideW-1:0]  run_length;
    logic [PosW-1:0]   row;
    logic [PosW-1:0]   start_column;
    logic              line_end;
    logic              field_done;
    logic              last;
  } res_t;

endpackage

@@ hdl/subpicture_rle_field_decoder.sv @@
// ----------------------------------------------------------------------------
// Subpicture RLE field decoder
// Decodes one interlaced field of run-length coded subpicture data into runs.
// ----------------------------------------------------------------------------
// Usage:
// RLE bytes enter on the s_axis channel, one item per byte; tuser marks the
// first byte of a new field. Decoded runs leave on the m_axis channel, one
// item per run, with tlast set on the last run caused by a byte.
// Configuration (line width, picture height, first row) is written through
// the cfg port; the user writes it only while idle. The block does not enforce it.
// A byte is taken into an input register and, once the result queue has room,
// decoded by two nibble decoders in series. Its runs are written to a
// four-entry result queue at the clock edge that ends the decode, and the
// first run is offered from the queue register, not straight from the decoder.
// One byte is accepted per cycle while each byte gives at most one run and
// the receiver does not stall; a byte that gives two runs holds the output
// channel for both in turn, since the output port carries a single run.
// Reset sets the registers to 720 x 576, top field, and leaves the decoder
// idle: bytes are dropped until one arrives with the field start flag.
// When the receiver stalls, the queue fills; once fewer than two entries are
// free, a byte in the input register waits and s_axis_tready_o falls. No run
// is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module subpicture_rle_field_decoder
  import srle_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port.
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [SideW-1:0] cfg_data_i,
  // Input items.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] rle_byte
  input  logic             s_axis_tuser_i,   // [0] field_start
  // Result items.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [1:0] color, [14:2] run_length,
                                             // [26:15] row, [38:27] start_column
  output logic [1:0]       m_axis_tuser_o,   // [0] line_end, [1] field_done
  output logic             m_axis_tlast_o
);

  localparam logic [SideW-1:0] MaxSide = SideW'(MAX_SIDE);

  logic [SideW-1:0] line_width_q, picture_height_q;
  logic             first_row_q;
  logic [SideW-1:0] width_eff, height_eff;
  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             start_q;
  logic             room, adv;
  logic             wr0, wr1;
  res_t             res0, res1, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q     <= LineWidthRst;
      picture_height_q <= PictureHeightRst;
      first_row_q      <= FirstRowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_WIDTH:     line_width_q     <= cfg_data_i;
        CFG_PICTURE_HEIGHT: picture_height_q <= cfg_data_i;
        CFG_FIRST_ROW:      first_row_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sizes saturated to the largest supported side.
  assign width_eff  = (line_width_q > MaxSide) ? MaxSide : line_width_q;
  assign height_eff = (picture_height_q > MaxSide) ? MaxSide : picture_height_q;

  // Input register; it drains whenever the queue has room for two runs.
  assign adv             = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q  <= s_axis_tdata_i;
      start_q <= s_axis_tuser_i;
    end
  end

  srle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .byte_i      (byte_q),
    .start_i     (start_q),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .first_row_i (first_row_q),
    .wr0_o       (wr0),
    .wr1_o       (wr1),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  srle_res_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr0_i   (wr0),
    .wr1_i   (wr1),
    .d0_i    (res0),
    .d1_i    (res1),
    .pop_i   (m_axis_tready_i),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .q_o     (head)
  );

  // Output packing.
  assign m_axis_tdata_o = {1'b0, head.start_column, head.row, head.run_length, head.color};
  assign m_axis_tuser_o = {head.field_done, head.line_end};
  assign m_axis_tlast_o = head.last;

  // A finished field always closes its line.
  `SRLE_ASSERT_IMPL(a_done_ends_line, m_axis_tvalid_o && head.field_done, head.line_end,
                    "field_done without line_end")
  // A second run from one byte only follows a run that left the line open.
  `SRLE_ASSERT_IMPL(a_second_run_open, wr1, wr0 && !res0.line_end && !res0.field_done,
                    "second run after a line end")
  // Runs never pass the widest supported line.
  `SRLE_ASSERT(a_run_in_line,
               !m_axis_tvalid_o ||
               ({1'b0, head.start_column} + head.run_length) <= MaxSide,
               "run extends past line")

endmodule

@@ hdl/srle_nibble.sv @@
// ----------------------------------------------------------------------------
// Nibble decoder
// Adds one nibble to the pending code and, once the code is complete,
// produces the clamped run and advances column, row and field status.
// ----------------------------------------------------------------------------
module srle_nibble
  import srle_pkg::*;
(
  input  logic             en_i,
  input  logic [3:0]       nib_i,
  input  dec_state_t       state_i,
  input  logic [SideW-1:0] width_i,
  input  logic [SideW-1:0] height_i,
  output dec_state_t       state_o,
  output logic             valid_o,
  output res_t             res_o
);

  logic [PartW+3:0] code;
  logic [2:0]       held_n;
  logic             short_code;
  logic [SideW-1:0] rem;
  logic [7:0]       run_raw;
  logic [SideW-1:0] run;
  logic [SideW-1:0] col_sum;
  logic [SideW-1:0] row_n;
  logic             ended;
  logic             done;

  // Code assembly and the end-of-code test.
  always_comb begin
    code       = {state_i.partial_code, nib_i};
    held_n     = {1'b0, state_i.nibbles_held} + 3'd1;
    short_code = (held_n == 3'd1 && code < 10'h4)  ||
                 (held_n == 3'd2 && code < 10'h10) ||
                 (held_n == 3'd3 && code < 10'h40);
  end

  // Run clamping and line/field bookkeeping.
  always_comb begin
    rem     = (state_i.column_pos < width_i) ? (width_i - state_i.column_pos) : '0;
    run_raw = code[9:2];
    if (run_raw == 8'd0 || {5'd0, run_raw} > rem) begin
      run = rem;
    end else begin
      run = {5'd0, run_raw};
    end
    col_sum = state_i.column_pos + run;
    ended   = (col_sum >= width_i);
    row_n   = state_i.row_pos + 13'd2;
    done    = ended && (row_n >= height_i);
  end

  // Next state and result.
  always_comb begin
    state_o = state_i;
    valid_o = 1'b0;
    if (en_i) begin
      if (short_code) begin
        state_o.partial_code = code[PartW-1:0];
        state_o.nibbles_held = held_n[1:0];
      end else begin
        valid_o              = 1'b1;
        state_o.partial_code = '0;
        state_o.nibbles_held = '0;
        state_o.column_pos   = ended ? '0 : col_sum;
        state_o.row_pos      = ended ? row_n : state_i.row_pos;
        state_o.field_finished = state_i.field_finished | done;
      end
    end
    res_o.color        = code[1:0];
    res_o.run_length   = run;
    res_o.row          = state_i.row_pos[PosW-1:0];
    res_o.start_column = state_i.column_pos[PosW-1:0];
    res_o.line_end     = ended;
    res_o.field_done   = done;
    res_o.last         = 1'b0;
  end

endmodule

@@ hdl/srle_core.sv @@
// ----------------------------------------------------------------------------
// Byte decoder core
// Holds the decoder state and runs the high and low nibble of one byte
// through two nibble decoders in series, giving up to two runs.
// ----------------------------------------------------------------------------
module srle_core
  import srle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       byte_i,
  input  logic             start_i,
  input  logic [SideW-1:0] width_i,
  input  logic [SideW-1:0] height_i,
  input  logic             first_row_i,
  output logic             wr0_o,
  output logic             wr1_o,
  output res_t             res0_o,
  output res_t             res1_o
);

  dec_state_t state_q, state_d;
  dec_state_t st0, st_a;
  logic       en_a, en_b;
  logic       v_a, v_b;
  res_t       res_a, res_b;

  // Field start clears the position before the byte is decoded.
  always_comb begin
    st0 = state_q;
    if (start_i) begin
      st0.column_pos     = '0;
      st0.partial_code   = '0;
      st0.nibbles_held   = '0;
      st0.row_pos        = {12'd0, first_row_i};
      st0.field_finished = ({12'd0, first_row_i} >= height_i) || (width_i == '0);
    end
    en_a = !st0.field_finished;
  end

  srle_nibble u_nib_hi (
    .en_i     (en_a),
    .nib_i    (byte_i[7:4]),
    .state_i  (st0),
    .width_i  (width_i),
    .height_i (height_i),
    .state_o  (st_a),
    .valid_o  (v_a),
    .res_o    (res_a)
  );

  // The low nibble is skipped once the high nibble ended a line or the field.
  assign en_b = en_a && !(v_a && res_a.line_end) && !st_a.field_finished;

  srle_nibble u_nib_lo (
    .en_i     (en_b),
    .nib_i    (byte_i[3:0]),
    .state_i  (st_a),
    .width_i  (width_i),
    .height_i (height_i),
    .state_o  (state_d),
    .valid_o  (v_b),
    .res_o    (res_b)
  );

  // Result ordering and the last-run flag.
  always_comb begin
    res0_o      = v_a ? res_a : res_b;
    res0_o.last = !(v_a && v_b);
    res1_o      = res_b;
    res1_o.last = 1'b1;
    wr0_o       = adv_i && (v_a || v_b);
    wr1_o       = adv_i && v_a && v_b;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{column_pos: '0, row_pos: '0, partial_code: '0,
                   nibbles_held: '0, field_finished: 1'b1};
    end else if (adv_i) begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/srle_res_fifo.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two runs a cycle and hands out
// one run a cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module srle_res_fifo
  import srle_pkg::*;
#(
  parameter int unsigned DEPTH = RES_FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr0_i,
  input  logic wr1_i,
  input  res_t d0_i,
  input  res_t d1_i,
  input  logic pop_i,
  output logic room_o,
  output logic valid_o,
  output res_t q_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  res_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  // Pointer and count updates.
  always_comb begin
    pop      = pop_i && (cnt_q != '0);
    wr_ptr_1 = ptr_inc(wr_ptr_q);
    wr_ptr_d = wr1_i ? ptr_inc(wr_ptr_1) : (wr0_i ? wr_ptr_1 : wr_ptr_q);
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(wr0_i) + CntW'(wr1_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wr_ptr_q] <= d0_i;
    end
    if (wr1_i) begin
      mem_q[wr_ptr_1] <= d1_i;
    end
  end

  assign room_o  = ({1'b0, cnt_q} + (CntW+1)'(2)) <= (CntW+1)'(DEPTH);
  assign valid_o = (cnt_q != '0);
  assign q_o     = mem_q[rd_ptr_q];

endmodule
